### sv/perspective_remap_pixel_fetch_macros.svh
// Assertion macros for the perspective remap pixel fetch block.
// Used by the top level; needs a clock and reset in scope.
`ifndef PERSPECTIVE_REMAP_PIXEL_FETCH_MACROS_SVH
`define PERSPECTIVE_REMAP_PIXEL_FETCH_MACROS_SVH

// Same-cycle implication, off during reset.
`define PRPF_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication with the consequent delayed by the dly argument.
`define PRPF_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##(dly) (cons)) \
      else $error(msg);

`endif

### sv/prpf_pkg.sv
// Shared constants, types and codes of the perspective remap pixel fetch block.
// No dependencies.
package prpf_pkg;

   localparam int SRC_WIDTH   = 640;
   localparam int SRC_HEIGHT  = 480;
   localparam int FRAME_DEPTH = SRC_WIDTH * SRC_HEIGHT;
   localparam int ADDR_W      = $clog2(FRAME_DEPTH);

   localparam int COL_W = 10;
   localparam int ROW_W = 9;
   localparam int RGB_W = 24;

   // quotient bits, magnitude bits and divisor bits of the two dividers
   localparam int Q_W   = 11;
   localparam int MAG_W = 24;
   localparam int DEN_W = 15;

   // three arithmetic stages, magnitude stage, divider stages, address, memory
   localparam int PIPE_DEPTH = 4 + Q_W + 2;

   localparam logic [25:0] SQRT2_Q24 = 26'd23726566;
   localparam logic [25:0] U_A0  = 26'd2794168;
   localparam logic [25:0] U_AI  = 26'd5213;
   localparam logic [23:0] U_T0  = 24'd3952854;
   localparam logic [23:0] U_TJ  = 24'd3195;
   localparam logic [DEN_W-1:0] U_D0 = 15'd12372;
   localparam logic [DEN_W-1:0] U_DJ = 15'd10;
   localparam logic [23:0] V_N0  = 24'd5151;
   localparam logic [23:0] V_NJ  = 24'd7045;
   localparam logic [DEN_W-1:0] V_D0 = 15'd30930;
   localparam logic [DEN_W-1:0] V_DJ = 15'd25;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_FETCH = 1'b1;

   typedef struct packed {
      logic             fetch;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [RGB_W-1:0] rgb;
   } item_type;

   typedef struct packed {
      logic              valid;
      logic              fetch;
      logic              mapped;
      logic              wr_en;
      logic [ADDR_W-1:0] addr;
      logic [RGB_W-1:0]  rgb;
   } mem_op_type;

endpackage

### sv/prpf_map.sv
// Coordinate mapping pipeline: multipliers, adders and two pipelined dividers.
// Depends on prpf_pkg; emits one frame memory operation per item.
module prpf_map
   import prpf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  item_type   in_item,
   output mem_op_type op
);

   // stage 1
   logic             s1_valid_ff;
   item_type         s1_item_ff;
   logic [25:0]      s1_ua_ff, s1_ua_in;
   logic [23:0]      s1_ut1_ff, s1_ut1_in, s1_vnum_ff, s1_vnum_in;
   logic [DEN_W-1:0] s1_uden_ff, s1_uden_in, s1_vden_ff, s1_vden_in;
   // stage 2
   logic             s2_valid_ff;
   item_type         s2_item_ff;
   logic [51:0]      s2_prod_ff, s2_prod_in;
   logic [23:0]      s2_ut1_ff, s2_vnum_ff;
   logic [DEN_W-1:0] s2_uden_ff, s2_vden_ff;
   // stage 3
   logic             s3_valid_ff;
   item_type         s3_item_ff;
   logic [51:0]      s3_unum_ff, s3_unum_in;
   logic [23:0]      s3_vnum_ff;
   logic [DEN_W-1:0] s3_uden_ff, s3_vden_ff;
   // divider stages; index 0 is the magnitude stage
   logic             d_valid_ff [0:Q_W];
   item_type         d_item_ff  [0:Q_W];
   logic             d_uneg_ff  [0:Q_W];
   logic             d_vneg_ff  [0:Q_W];
   logic [MAG_W-1:0] d_urem_ff  [0:Q_W];
   logic [MAG_W-1:0] d_vrem_ff  [0:Q_W];
   logic [Q_W-1:0]   d_uq_ff    [0:Q_W];
   logic [Q_W-1:0]   d_vq_ff    [0:Q_W];
   logic [DEN_W-1:0] d_uden_ff  [0:Q_W];
   logic [DEN_W-1:0] d_vden_ff  [0:Q_W];
   logic [51:0]      umag_full;
   logic [23:0]      vmag_full;
   // address stage
   mem_op_type       op_ff, op_in;
   logic [Q_W-1:0]   fin_uq, fin_vq;

   assign s1_ua_in   = U_A0 - 26'(in_item.col) * U_AI;
   assign s1_ut1_in  = 24'(in_item.row) * U_TJ - U_T0;
   assign s1_vnum_in = V_N0 - 24'(in_item.row) * V_NJ;
   assign s1_uden_in = U_D0 - 15'(in_item.row) * U_DJ;
   assign s1_vden_in = V_D0 - 15'(in_item.row) * V_DJ;

   assign s2_prod_in = 52'($signed(s1_ua_ff) * $signed(SQRT2_Q24));

   assign s3_unum_in = {{4{s2_ut1_ff[23]}}, s2_ut1_ff, 24'b0} + s2_prod_ff;

   assign umag_full = s3_unum_ff[51] ? (~s3_unum_ff + 52'd1) : s3_unum_ff;
   assign vmag_full = s3_vnum_ff[23] ? (~s3_vnum_ff + 24'd1) : s3_vnum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         d_valid_ff[0] <= 1'b0;
      end else begin
         s1_valid_ff   <= in_valid;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         d_valid_ff[0] <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= in_item;
      s1_ua_ff   <= s1_ua_in;
      s1_ut1_ff  <= s1_ut1_in;
      s1_vnum_ff <= s1_vnum_in;
      s1_uden_ff <= s1_uden_in;
      s1_vden_ff <= s1_vden_in;

      s2_item_ff <= s1_item_ff;
      s2_prod_ff <= s2_prod_in;
      s2_ut1_ff  <= s1_ut1_ff;
      s2_vnum_ff <= s1_vnum_ff;
      s2_uden_ff <= s1_uden_ff;
      s2_vden_ff <= s1_vden_ff;

      s3_item_ff <= s2_item_ff;
      s3_unum_ff <= s3_unum_in;
      s3_vnum_ff <= s2_vnum_ff;
      s3_uden_ff <= s2_uden_ff;
      s3_vden_ff <= s2_vden_ff;

      // drop the 24 fraction bits: floor of floor gives the same quotient
      d_item_ff[0] <= s3_item_ff;
      d_uneg_ff[0] <= s3_unum_ff[51];
      d_vneg_ff[0] <= s3_vnum_ff[23];
      d_urem_ff[0] <= umag_full[47:24];
      d_vrem_ff[0] <= vmag_full;
      d_uq_ff[0]   <= '0;
      d_vq_ff[0]   <= '0;
      d_uden_ff[0] <= s3_uden_ff;
      d_vden_ff[0] <= s3_vden_ff;
   end

   // one restoring quotient bit per stage, most significant first
   for (genvar k = 0; k < Q_W; k++) begin : g_div
      localparam int SH = Q_W - 1 - k;
      logic [MAG_W+1:0] u_trial, v_trial;
      logic             u_ge, v_ge;

      assign u_trial = (MAG_W+2)'(d_uden_ff[k]) << SH;
      assign v_trial = (MAG_W+2)'(d_vden_ff[k]) << SH;
      assign u_ge    = (MAG_W+2)'(d_urem_ff[k]) >= u_trial;
      assign v_ge    = (MAG_W+2)'(d_vrem_ff[k]) >= v_trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            d_valid_ff[k+1] <= 1'b0;
         end else begin
            d_valid_ff[k+1] <= d_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         d_item_ff[k+1] <= d_item_ff[k];
         d_uneg_ff[k+1] <= d_uneg_ff[k];
         d_vneg_ff[k+1] <= d_vneg_ff[k];
         d_uden_ff[k+1] <= d_uden_ff[k];
         d_vden_ff[k+1] <= d_vden_ff[k];
         d_urem_ff[k+1] <= u_ge ? MAG_W'((MAG_W+2)'(d_urem_ff[k]) - u_trial) : d_urem_ff[k];
         d_vrem_ff[k+1] <= v_ge ? MAG_W'((MAG_W+2)'(d_vrem_ff[k]) - v_trial) : d_vrem_ff[k];
         d_uq_ff[k+1]   <= {d_uq_ff[k][Q_W-2:0], u_ge};
         d_vq_ff[k+1]   <= {d_vq_ff[k][Q_W-2:0], v_ge};
      end
   end

   assign fin_uq = d_uq_ff[Q_W];
   assign fin_vq = d_vq_ff[Q_W];

   // divisors are always negative: a negative numerator gives a non-negative result
   always_comb begin
      op_in.valid  = d_valid_ff[Q_W];
      op_in.fetch  = d_item_ff[Q_W].fetch == CMD_FETCH;
      op_in.rgb    = d_item_ff[Q_W].rgb;
      op_in.mapped = op_in.fetch
                     && (d_uneg_ff[Q_W] || fin_uq == '0) && 32'(fin_uq) < SRC_WIDTH
                     && (d_vneg_ff[Q_W] || fin_vq == '0) && 32'(fin_vq) < SRC_HEIGHT;
      op_in.wr_en  = !op_in.fetch
                     && 32'(d_item_ff[Q_W].col) < SRC_WIDTH
                     && 32'(d_item_ff[Q_W].row) < SRC_HEIGHT;
      if (op_in.fetch) begin
         op_in.addr = ADDR_W'(32'(fin_vq) * 32'(SRC_WIDTH) + 32'(fin_uq));
      end else begin
         op_in.addr = ADDR_W'(32'(d_item_ff[Q_W].row) * 32'(SRC_WIDTH)
                              + 32'(d_item_ff[Q_W].col));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff.valid <= 1'b0;
      end else begin
         op_ff.valid <= op_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      op_ff.fetch  <= op_in.fetch;
      op_ff.mapped <= op_in.mapped;
      op_ff.wr_en  <= op_in.wr_en;
      op_ff.addr   <= op_in.addr;
      op_ff.rgb    <= op_in.rgb;
   end

   assign op = op_ff;

endmodule

### sv/prpf_frame.sv
// Source frame memory with one access per cycle and a registered read word.
// Depends on prpf_pkg; fed by prpf_map.
module prpf_frame
   import prpf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  mem_op_type       op,
   output logic             rsp_valid,
   output logic [RGB_W-1:0] rsp_rgb_out,
   output logic             rsp_mapped
);

   logic [RGB_W-1:0] frame_mem [0:FRAME_DEPTH-1];
   logic [RGB_W-1:0] rd_data_ff;
   logic             valid_ff, mapped_ff;

   always_ff @(posedge clock) begin
      if (op.valid && op.wr_en) begin
         frame_mem[op.addr] <= op.rgb;
      end
      rd_data_ff <= frame_mem[op.addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         mapped_ff <= 1'b0;
      end else begin
         valid_ff  <= op.valid && op.fetch;
         mapped_ff <= op.valid && op.mapped;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_mapped  = mapped_ff;
   assign rsp_rgb_out = mapped_ff ? rd_data_ff : '0;

endmodule

### sv/perspective_remap_pixel_fetch.sv
// Perspective remap pixel fetch: frame store with a fixed top-view remap.
// Pipeline: stages 1-3, magnitude, 11 divider stages, address and read registers.
// Throughput: one word per cycle outside reset, loads and fetches mixed; set by the
// one frame port. Divider stages give one quotient bit each; results cannot stall.
// Reset: synchronous; clears all pipeline valid bits, frame contents stay undefined.
// Depends on prpf_pkg, prpf_map, prpf_frame and the assertion macro header.
`include "perspective_remap_pixel_fetch_macros.svh"

module perspective_remap_pixel_fetch
   import prpf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_cmd,
   input  logic [COL_W-1:0] req_col,
   input  logic [ROW_W-1:0] req_row,
   input  logic [RGB_W-1:0] req_rgb_in,
   output logic             rsp_valid,
   output logic [RGB_W-1:0] rsp_rgb_out,
   output logic             rsp_mapped
);

   item_type   req_item;
   logic       req_fire;
   logic       fetch_fire;
   logic       load_fire;
   mem_op_type mem_op;

   // hold off words only while reset clears the pipeline
   assign busy     = reset;
   assign req_fire = start && !busy;

   assign fetch_fire = req_fire && req_cmd == CMD_FETCH;
   assign load_fire  = req_fire && req_cmd == CMD_LOAD;

   assign req_item.fetch = req_cmd;
   assign req_item.col   = req_col;
   assign req_item.row   = req_row;
   assign req_item.rgb   = req_rgb_in;

   // loads travel the same pipeline so memory accesses keep word order
   prpf_map u_map (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_fire),
      .in_item  (req_item),
      .op       (mem_op)
   );

   prpf_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .op          (mem_op),
      .rsp_valid   (rsp_valid),
      .rsp_rgb_out (rsp_rgb_out),
      .rsp_mapped  (rsp_mapped)
   );

   `PRPF_ASSERT_DELAY(a_fetch_answers, fetch_fire, PIPE_DEPTH, rsp_valid, "fetch lost")
   `PRPF_ASSERT_DELAY(a_load_silent, load_fire, PIPE_DEPTH, !rsp_valid, "load answered")
   `PRPF_ASSERT_IMPL(a_mapped_valid, rsp_mapped, rsp_valid, "mapped without result")

endmodule

### bench/perspective_remap_pixel_fetch_tb.sv
// Self-checking bench for perspective_remap_pixel_fetch: loads and fetches
// with random gaps, results checked against a built-in remap predictor.
// Depends on prpf_pkg and the block's RTL.
`timescale 1ns / 1ps

module perspective_remap_pixel_fetch_tb
   import prpf_pkg::*;
();

   localparam int  WATCHDOG_LIMIT = 4000;
   localparam int  DRAIN_CYCLES   = PIPE_DEPTH + 8;
   localparam int  ITEM_TARGET    = 1050;
   localparam longint SQRT2_FIX   = 64'd23726566;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic             req_cmd;
   logic [COL_W-1:0] req_col;
   logic [ROW_W-1:0] req_row;
   logic [RGB_W-1:0] req_rgb_in;
   logic             rsp_valid;
   logic [RGB_W-1:0] rsp_rgb_out;
   logic             rsp_mapped;

   typedef struct {
      logic [RGB_W-1:0] rgb;
      logic             mapped;
   } pixel_result_type;

   item_type         pending_words[$];
   pixel_result_type expected_pixels[$];

   // predictor copy of the frame, and which entries the stimulus has written
   logic [RGB_W-1:0] frame_copy [0:FRAME_DEPTH-1];
   bit               entry_written [0:FRAME_DEPTH-1];

   int  error_count;
   int  idle_cycles;
   int  gap_left;
   bit  no_gap_run;
   bit  word_moved;

   perspective_remap_pixel_fetch u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_cmd    (req_cmd),
      .req_col    (req_col),
      .req_row    (req_row),
      .req_rgb_in (req_rgb_in),
      .rsp_valid  (rsp_valid),
      .rsp_rgb_out(rsp_rgb_out),
      .rsp_mapped (rsp_mapped)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Map output pixel (i,j) to a source address; return 1 when it lands inside
   // the source frame. Division truncates toward zero, as the hardware does.
   function automatic bit remap_source(input int unsigned i, input int unsigned j,
                                       output int unsigned addr);
      longint ii;
      longint jj;
      longint u_num;
      longint u_den;
      longint v_num;
      longint v_den;
      longint u;
      longint v;
      ii = i;
      jj = j;
      u_num = (64'sd3195 * jj - 64'sd3952854) * (64'sd1 <<< 24)
            + SQRT2_FIX * (64'sd2794168 - 64'sd5213 * ii);
      u_den = (64'sd10 * jj - 64'sd12372) * (64'sd1 <<< 24);
      v_num = 64'sd5151 - 64'sd7045 * jj;
      v_den = 64'sd25 * jj - 64'sd30930;
      addr = 0;
      // zero divisor cannot happen for integer rows; treat as unmapped anyway
      if (u_den == 0 || v_den == 0)
         return 1'b0;
      u = u_num / u_den;
      v = v_num / v_den;
      if (u < 0 || u >= SRC_WIDTH || v < 0 || v >= SRC_HEIGHT)
         return 1'b0;
      addr = int'(v) * SRC_WIDTH + int'(u);
      return 1'b1;
   endfunction

   // Queue a load word; in-frame loads mark their entry as written.
   task automatic queue_load(input int unsigned c, input int unsigned r,
                             input logic [RGB_W-1:0] rgb);
      item_type w;
      w.fetch = CMD_LOAD;
      w.col   = c[COL_W-1:0];
      w.row   = r[ROW_W-1:0];
      w.rgb   = rgb;
      pending_words.push_back(w);
      if (c < SRC_WIDTH && r < SRC_HEIGHT)
         entry_written[r * SRC_WIDTH + c] = 1'b1;
   endtask

   // Queue a fetch word; write its source entry first if nothing has yet.
   task automatic queue_fetch(input int unsigned i, input int unsigned j);
      item_type    w;
      int unsigned addr;
      if (remap_source(i, j, addr) && !entry_written[addr])
         queue_load(addr % SRC_WIDTH, addr / SRC_WIDTH, RGB_W'($urandom));
      w.fetch = CMD_FETCH;
      w.col   = i[COL_W-1:0];
      w.row   = j[ROW_W-1:0];
      w.rgb   = RGB_W'($urandom);
      pending_words.push_back(w);
   endtask

   // Work out what an accepted word does to the frame and what it returns.
   task automatic predict_word(input item_type w);
      pixel_result_type exp_px;
      int unsigned      addr;
      if (w.fetch == CMD_LOAD) begin
         if (w.col < SRC_WIDTH && w.row < SRC_HEIGHT)
            frame_copy[w.row * SRC_WIDTH + w.col] = w.rgb;
      end else begin
         exp_px.mapped = remap_source(w.col, w.row, addr);
         exp_px.rgb    = exp_px.mapped ? frame_copy[addr] : '0;
         expected_pixels.push_back(exp_px);
      end
   endtask

   // Mostly short gaps, a few long ones, and runs with none at all.
   function automatic int pick_gap();
      int roll;
      if ($urandom_range(0, 49) == 0)
         no_gap_run = !no_gap_run;
      if (no_gap_run)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // Driver: hold a word until it is taken, then advance after a random gap.
   always @(posedge clock) begin
      item_type w;
      bit       taken;
      if (reset) begin
         start    <= 1'b0;
         gap_left  = 0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            w.fetch = req_cmd;
            w.col   = req_col;
            w.row   = req_row;
            w.rgb   = req_rgb_in;
            predict_word(w);
            gap_left = pick_gap();
         end
         if (start && !taken) begin
            // hold: busy is stalling the current word
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_words.size() != 0) begin
            w = pending_words.pop_front();
            start      <= 1'b1;
            req_cmd    <= w.fetch;
            req_col    <= w.col;
            req_row    <= w.row;
            req_rgb_in <= w.rgb;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobed result is checked against the oldest expectation.
   always @(posedge clock) begin
      pixel_result_type exp_px;
      if (!reset && rsp_valid) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result word: rgb_out %h mapped %b", rsp_rgb_out, rsp_mapped);
            error_count++;
         end else begin
            exp_px = expected_pixels.pop_front();
            if (rsp_rgb_out !== exp_px.rgb) begin
               $error("rgb_out: expected %h, got %h", exp_px.rgb, rsp_rgb_out);
               error_count++;
            end
            if (rsp_mapped !== exp_px.mapped) begin
               $error("mapped: expected %b, got %b", exp_px.mapped, rsp_mapped);
               error_count++;
            end
         end
      end
   end

   // Watchdog: drop the run if no word moves on either side for too long.
   always @(posedge clock) begin
      word_moved = (start && !busy) || rsp_valid;
      if (reset || word_moved)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      no_gap_run  = 1'b0;
      start       = 1'b0;
      req_cmd     = CMD_LOAD;
      req_col     = '0;
      req_row     = '0;
      req_rgb_in  = '0;
      reset       = 1'b1;
      for (int k = 0; k < FRAME_DEPTH; k++) begin
         frame_copy[k]    = '0;
         entry_written[k] = 1'b0;
      end

      // directed: frame corners, ignored out-of-frame loads, extreme fetches
      queue_load(0, 0, 24'h000000);
      queue_load(SRC_WIDTH - 1, SRC_HEIGHT - 1, 24'hFFFFFF);
      queue_load(1023, 511, 24'hFFFFFF);
      queue_load(SRC_WIDTH, 0, 24'hA5A5A5);
      queue_load(0, SRC_HEIGHT, 24'h5A5A5A);
      queue_load(0, SRC_HEIGHT - 1, 24'h123456);
      queue_load(SRC_WIDTH - 1, 0, 24'hFEDCBA);
      queue_fetch(0, 0);
      queue_fetch(1023, 0);
      queue_fetch(0, 511);
      queue_fetch(1023, 511);
      queue_fetch(SRC_WIDTH - 1, 480);
      queue_fetch(SRC_WIDTH, 255);
      queue_fetch(320, 256);
      queue_fetch(320, 100);
      queue_fetch(320, 400);
      queue_fetch(512, 383);
      queue_fetch(100, 300);
      queue_fetch(600, 450);

      // random: mostly fetches over the full field range, loads mostly inside the frame
      while (pending_words.size() < ITEM_TARGET) begin
         if ($urandom_range(0, 99) < 60)
            queue_fetch($urandom_range(0, 1023), $urandom_range(0, 511));
         else if ($urandom_range(0, 9) == 0)
            queue_load($urandom_range(0, 1023), $urandom_range(0, 511), RGB_W'($urandom));
         else
            queue_load($urandom_range(0, SRC_WIDTH - 1), $urandom_range(0, SRC_HEIGHT - 1),
                       RGB_W'($urandom));
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || start)
         @(posedge clock);
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/prpf_pkg.sv
sv/prpf_map.sv
sv/prpf_frame.sv
sv/perspective_remap_pixel_fetch.sv
bench/perspective_remap_pixel_fetch_tb.sv
